### hdl/pddc_pkg.sv
// shared constants and types for the pendant button debounce and detent counter
`default_nettype none
package pddc_pkg;

  localparam int NumButtons = 3;
  localparam int TimeW      = 32;
  localparam int CountW     = 16;
  localparam int StepsW     = 15;
  localparam int RemW       = 3;
  localparam int DebounceW  = 8;
  localparam int DelayW     = 16;
  localparam int CfgDataW   = 16;
  localparam int CfgAddrW   = 2;
  localparam int InDataW    = 56;
  localparam int OutDataW   = 24;

  localparam logic [DebounceW-1:0]  DebounceReset = 8'd30;
  localparam logic [DelayW-1:0]     DelayReset    = 16'd500;
  localparam logic [NumButtons-1:0] EnableReset   = 3'b111;
  localparam logic [NumButtons-1:0] LevelReset    = 3'b111;

  typedef enum logic [CfgAddrW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_UNLOCK_DELAY = 2'd1,
    REG_BUTTON_ENABLE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [StepsW-1:0]     detent_steps;
    logic [NumButtons-1:0] press_events;
    logic                  unlock_request;
  } result_t;

endpackage
`default_nettype wire

### hdl/pendant_button_debounce_detent_counter_top.sv
// pendant button debounce and quadrature detent counter, single-pass top level
//
//   channel | dir | fields (lsb first)
//   s_*     | in  | now_ms[31:0], buttons_raw[34:32], encoder_count[50:35], zero pad
//   m_*     | out | detent_steps[14:0], press_events[17:15], unlock_request[18], pad
//   cfg_*   | in  | cfg_addr selects debounce_ms, unlock_delay_ms, button_enable
//
// one poll per clock; the result is in the output register the cycle after accept
// all state updates in the accept cycle, so polls may follow back to back
// a full output register that is not taken holds off s_tready
// rst is synchronous and active high; it restores the register defaults
`default_nettype none
module pendant_button_debounce_detent_counter_top
  import pddc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // now_ms, buttons_raw, encoder_count, zero pad
  input  wire logic [InDataW-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // detent_steps, press_events, unlock_request, zero pad
  output logic [OutDataW-1:0]      m_tdata,
  input  wire logic                cfg_wen,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  logic [DebounceW-1:0]  debounce_ms;
  logic [DelayW-1:0]     unlock_delay_ms;
  logic [NumButtons-1:0] button_enable;

  logic [CountW-1:0]     last_count, last_count_next;
  logic                  count_primed, count_primed_next;
  logic [RemW-1:0]       detent_remainder, detent_remainder_next;
  logic [NumButtons-1:0] last_level, last_level_next;
  logic [TimeW-1:0]      change_time [NumButtons];
  logic [TimeW-1:0]      change_time_next [NumButtons];
  logic [NumButtons-1:0] stable_level, stable_level_next;
  logic [NumButtons-1:0] press_handled, press_handled_next;
  logic                  unlock_pending, unlock_pending_next;
  logic [TimeW-1:0]      unlock_start, unlock_start_next;

  logic                  in_acc;
  logic [TimeW-1:0]      now_ms;
  logic [NumButtons-1:0] buttons_raw;
  logic [CountW-1:0]     encoder_count;
  logic [CountW-1:0]     delta;
  logic [CountW:0]       acc;
  logic [CountW-1:0]     quo;
  logic [TimeW-1:0]      elapsed [NumButtons];
  logic [TimeW-1:0]      unlock_elapsed;
  result_t               res_next;
  result_t               res;

  assign now_ms        = s_tdata[TimeW-1:0];
  assign buttons_raw   = s_tdata[TimeW+NumButtons-1:TimeW];
  assign encoder_count = s_tdata[TimeW+NumButtons+CountW-1:TimeW+NumButtons];

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;

  always_comb begin
    last_count_next       = last_count;
    count_primed_next     = 1'b1;
    detent_remainder_next = detent_remainder;
    res_next              = '0;

    delta = encoder_count - last_count;
    acc   = {delta[CountW-1], delta} + {{(CountW+1-RemW){detent_remainder[RemW-1]}},
                                        detent_remainder};
    // arithmetic shift floors, bump negatives with a fraction to truncate toward zero
    quo = (acc[CountW] && (acc[1:0] != 2'b00)) ?
          ({acc[CountW], acc[CountW:2]} + 16'd1) : {acc[CountW], acc[CountW:2]};

    if (!count_primed) begin
      last_count_next = encoder_count;
    end else if (delta != '0) begin
      last_count_next       = encoder_count;
      res_next.detent_steps = quo[StepsW-1:0];
      // acc - 4*quo, taken mod 8
      detent_remainder_next = acc[RemW-1:0] - {quo[0], 2'b00};
    end

    last_level_next     = last_level;
    stable_level_next   = stable_level;
    press_handled_next  = press_handled;
    unlock_pending_next = unlock_pending;
    unlock_start_next   = unlock_start;
    for (int i = 0; i < NumButtons; i++) begin
      change_time_next[i] = change_time[i];
      elapsed[i]          = now_ms - change_time[i];
      if (button_enable[i]) begin
        if (buttons_raw[i] != last_level[i]) begin
          change_time_next[i] = now_ms;
          elapsed[i]          = '0;
        end
        last_level_next[i] = buttons_raw[i];
        if (elapsed[i] > {{(TimeW-DebounceW){1'b0}}, debounce_ms}) begin
          if (!buttons_raw[i] && stable_level[i] && !press_handled[i]) begin
            press_handled_next[i]    = 1'b1;
            res_next.press_events[i] = 1'b1;
            if (i == 0) begin
              unlock_pending_next = 1'b1;
              unlock_start_next   = now_ms;
            end
          end
          if (buttons_raw[i]) begin
            press_handled_next[i] = 1'b0;
          end
          stable_level_next[i] = buttons_raw[i];
        end
      end
    end

    unlock_elapsed = now_ms - unlock_start_next;
    if (unlock_pending_next &&
        unlock_elapsed >= {{(TimeW-DelayW){1'b0}}, unlock_delay_ms}) begin
      res_next.unlock_request = 1'b1;
      unlock_pending_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms     <= DebounceReset;
      unlock_delay_ms <= DelayReset;
      button_enable   <= EnableReset;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_DEBOUNCE:      debounce_ms     <= cfg_wdata[DebounceW-1:0];
        REG_UNLOCK_DELAY:  unlock_delay_ms <= cfg_wdata[DelayW-1:0];
        REG_BUTTON_ENABLE: button_enable   <= cfg_wdata[NumButtons-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count       <= '0;
      count_primed     <= 1'b0;
      detent_remainder <= '0;
      last_level       <= LevelReset;
      stable_level     <= LevelReset;
      press_handled    <= '0;
      unlock_pending   <= 1'b0;
      unlock_start     <= '0;
      for (int i = 0; i < NumButtons; i++) begin
        change_time[i] <= '0;
      end
    end else if (in_acc) begin
      last_count       <= last_count_next;
      count_primed     <= count_primed_next;
      detent_remainder <= detent_remainder_next;
      last_level       <= last_level_next;
      stable_level     <= stable_level_next;
      press_handled    <= press_handled_next;
      unlock_pending   <= unlock_pending_next;
      unlock_start     <= unlock_start_next;
      for (int i = 0; i < NumButtons; i++) begin
        change_time[i] <= change_time_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(OutDataW-StepsW-NumButtons-1){1'b0}},
                    res.unlock_request, res.press_events, res.detent_steps};

`ifndef SYNTH
  // remainder of a truncating divide by four never reaches minus four
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    detent_remainder != 3'b100)
    else $error("detent remainder out of range");

  // a reported press leaves its button marked handled
  a_press_handled: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> ((press_handled & $past(res_next.press_events)) ==
                $past(res_next.press_events)))
    else $error("press reported without handled mark");

  // an unlock that falls due disarms the pending request
  a_unlock_clear: assert property (@(posedge clk) disable iff (rst)
    (in_acc && res_next.unlock_request) |=> !unlock_pending)
    else $error("unlock still pending after request");

  // detents only once the baseline count is captured
  a_steps_primed: assert property (@(posedge clk) disable iff (rst)
    (in_acc && res_next.detent_steps != '0) |-> count_primed)
    else $error("detent steps before baseline");

  // an empty output register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");
`endif

endmodule
`default_nettype wire
